[hw/rtl/tgps_pkg.sv]
// Shared types and constants of the two-grain pitch shifter.
package tgps_pkg;

  // Field and port widths.
  localparam int SAMPLE_W    = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 19;

  // Operand and product widths of the shared multiplier.
  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_PITCH_RATIO      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIX_GAIN         = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOP_LENGTH       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESTART_DELAY    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BYPASS_TOLERANCE = 3'd4;

  // Ratio limits and unity, Q3.16.
  localparam logic [18:0] RATIO_MIN  = 19'd16384;
  localparam logic [18:0] RATIO_MAX  = 19'd262144;
  localparam logic [18:0] RATIO_ONE  = 19'd65536;
  localparam logic [16:0] MIX_ONE    = 17'd65536;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_DRY,
    ST_DRY_LATCH,
    ST_IDX,
    ST_RD0,
    ST_RD1,
    ST_DIF,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/tgps_sample_mem.sv]
// Circular sample store: one write port and one registered read port.
module tgps_sample_mem #(
  parameter int DEPTH = 8192
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [$clog2(DEPTH)-1:0]             wr_addr,
  input  logic signed [tgps_pkg::SAMPLE_W-1:0] wr_data,
  input  logic [$clog2(DEPTH)-1:0]             rd_addr,
  output logic signed [tgps_pkg::SAMPLE_W-1:0] rd_data
);
  import tgps_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // Write and read in one clocked block; the read is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/tgps_hann_rom.sv]
// Hann window table, built at elaboration, with a registered read.
module tgps_hann_rom #(
  parameter int WINDOW_LENGTH = 2048
) (
  input  logic                             clk,
  input  logic [$clog2(WINDOW_LENGTH)-1:0] rd_addr,
  output logic [15:0]                      rd_data
);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] HALF_WL = 64'(WINDOW_LENGTH / 2);
  localparam logic [63:0] WL64    = 64'(WINDOW_LENGTH);

  typedef logic [WINDOW_LENGTH:0][15:0] hann_tab_t;

  // Sine squared by a Taylor series in Q30, folded about the centre.
  function automatic hann_tab_t build_tab();
    hann_tab_t   tab;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] h;
    for (int n = 0; n <= WINDOW_LENGTH; n++) begin
      m  = (n <= WINDOW_LENGTH - n) ? 64'(n) : 64'(WINDOW_LENGTH - n);
      x  = (PI_Q30 * m + HALF_WL) / WL64;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      h  = (s * s + (64'd1 << 43)) >> 44;
      tab[n] = (h > 64'd65535) ? 16'hFFFF : h[15:0];
    end
    return tab;
  endfunction

  localparam hann_tab_t HANN = build_tab();

  // Registered table read.
  always_ff @(posedge clk) begin
    rd_data <= HANN[rd_addr];
  end

endmodule

[hw/rtl/tgps_mul.sv]
// Shared signed multiplier with a registered product.
module tgps_mul (
  input  logic                                clk,
  input  logic signed [tgps_pkg::MUL_A_W-1:0] op_a,
  input  logic signed [tgps_pkg::MUL_B_W-1:0] op_b,
  output logic signed [tgps_pkg::MUL_P_W-1:0] prod
);
  import tgps_pkg::*;

  // One product per cycle, available on the next.
  always_ff @(posedge clk) begin
    prod <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
  end

endmodule

[hw/rtl/two_grain_delay_pitch_shifter.sv]
// Top level of the two-grain delay-line pitch shifter.
// Each input item is one signed 24-bit sample and gives one mixed sample. The block works on
// one item at a time under a sequencer that drives a single shared multiplier and the one
// read port of the sample store. When the ratio lies within the bypass tolerance of one, the
// grain steps are skipped. The next item can be accepted in the cycle after the result is
// presented. Outside bypass an item makes eleven multiplications and five store reads, which
// pass one at a time through those two units. A finished result waits in the output
// register while the next item is accepted and processed; that item's result is held back
// until the register is free. After reset the store is cleared, and no item is accepted until
// the clearing is done. Configuration writes are taken only while clearing or idle, ahead of
// a waiting item. BUFFER_DEPTH must be a power of two.
module two_grain_delay_pitch_shifter #(
  parameter int WINDOW_LENGTH = 2048,
  parameter int BUFFER_DEPTH  = 8192
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tgps_pkg::SAMPLE_W-1:0]       s_axis_tdata,   // [23:0] in_sample
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tgps_pkg::SAMPLE_W-1:0]       m_axis_tdata,   // [23:0] out_sample
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tgps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tgps_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tgps_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int POS_W  = $clog2(WINDOW_LENGTH);
  localparam int IDX_W  = ADDR_W + 16;
  localparam logic [ADDR_W-1:0] DRY_OFF  = ADDR_W'(WINDOW_LENGTH % BUFFER_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADR = ADDR_W'(BUFFER_DEPTH - 1);
  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(WINDOW_LENGTH - 1);

  state_t state, state_next;

  // Configuration registers.
  logic [18:0] pitch_ratio;
  logic [16:0] mix_gain;
  logic [13:0] hop_length;
  logic [12:0] restart_delay;
  logic [15:0] bypass_tolerance;

  // Persistent grain state.
  logic [ADDR_W-1:0] wp;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] start1;
  logic [ADDR_W-1:0] start2;
  logic              unstarted;
  logic [ADDR_W-1:0] clr_cnt;

  // Per-item working registers.
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] dry_r;
  logic signed [SAMPLE_W-1:0] s0_r;
  logic [18:0]                ratio_c;
  logic [16:0]                mix_c;
  logic                       bypass_r;
  logic                       gsel;
  logic [ADDR_W-1:0]          i0_r;
  logic [15:0]                frac_r;
  logic [15:0]                pl_r;
  logic signed [43:0]         acc;
  logic signed [MUL_P_W-1:0]  tot;
  logic [SAMPLE_W-1:0]        sat_r;
  logic [SAMPLE_W-1:0]        res_r;

  // Unit connections.
  logic                       mem_wr_en;
  logic [ADDR_W-1:0]          mem_wr_addr;
  logic signed [SAMPLE_W-1:0] mem_wr_data;
  logic [ADDR_W-1:0]          mem_rd_addr;
  logic signed [SAMPLE_W-1:0] mem_rd_data;
  logic [15:0]                win;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  prod;

  // Derived values.
  logic [18:0]                ratio_in;
  logic [16:0]                mix_in;
  logic [18:0]                ratio_dist;
  logic                       bypass_in;
  logic [13:0]                hop_eff;
  logic [15:0]                dly1;
  logic [15:0]                dly2;
  logic [15:0]                diff1;
  logic [15:0]                diff2;
  logic [ADDR_W-1:0]          st1_new;
  logic [ADDR_W-1:0]          st2_new;
  logic [ADDR_W-1:0]          g_start;
  logic [IDX_W-1:0]           idx_sum;
  logic signed [SAMPLE_W:0]   s_diff;
  logic signed [MUL_A_W-1:0]  s0ph;
  logic [16:0]                dry_gain;
  logic signed [63:0]         fin;
  logic signed [31:0]         fin_hi;
  logic                       in_acc;
  logic                       out_free;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == ST_IDLE) || (state == ST_CLEAR);
  assign m_axis_tdata  = res_r;

  // Register clamps and the bypass band.
  assign ratio_in   = (pitch_ratio < RATIO_MIN) ? RATIO_MIN :
                      ((pitch_ratio > RATIO_MAX) ? RATIO_MAX : pitch_ratio);
  assign mix_in     = (mix_gain > MIX_ONE) ? MIX_ONE : mix_gain;
  assign ratio_dist = (ratio_in > RATIO_ONE) ? (ratio_in - RATIO_ONE) :
                      (RATIO_ONE - ratio_in);
  assign bypass_in  = (ratio_dist < {3'b000, bypass_tolerance});
  assign hop_eff    = (hop_length == 14'd0) ? 14'd1 : hop_length;

  // Restart points behind the write pointer, wrapping in the store.
  assign dly1    = 16'(restart_delay);
  assign dly2    = 16'(restart_delay) + 16'(hop_eff);
  assign diff1   = 16'(wp) - dly1;
  assign diff2   = 16'(wp) - dly2;
  assign st1_new = diff1[ADDR_W-1:0];
  assign st2_new = diff2[ADDR_W-1:0];

  // Grain read position, Q16 within the store.
  assign g_start  = gsel ? start2 : start1;
  assign idx_sum  = {g_start, 16'h0000} + prod[IDX_W-1:0];
  assign s_diff   = (SAMPLE_W + 1)'(mem_rd_data) - (SAMPLE_W + 1)'(s0_r);
  assign s0ph     = MUL_A_W'(s0_r) + MUL_A_W'(prod >>> 16);
  assign dry_gain = MIX_ONE - mix_c;

  // Final rounding; the top word is the scaled sum rounded to nearest, ties upward.
  assign fin    = (64'(tot) <<< 16) + 64'(prod) + 64'sh80000000;
  assign fin_hi = fin[63:32];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_ratio      <= 19'd65536;
      mix_gain         <= 17'd65536;
      hop_length       <= 14'd1024;
      restart_delay    <= 13'd2048;
      bypass_tolerance <= 16'd66;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PITCH_RATIO:      pitch_ratio      <= cfg_data[18:0];
        CFG_MIX_GAIN:         mix_gain         <= cfg_data[16:0];
        CFG_HOP_LENGTH:       hop_length       <= cfg_data[13:0];
        CFG_RESTART_DELAY:    restart_delay    <= cfg_data[12:0];
        CFG_BYPASS_TOLERANCE: bypass_tolerance <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:     if (clr_cnt == LAST_ADR) state_next = ST_IDLE;
      ST_IDLE:      if (in_acc) state_next = ST_WRITE;
      ST_WRITE:     state_next = ST_DRY;
      ST_DRY:       state_next = ST_DRY_LATCH;
      ST_DRY_LATCH: state_next = bypass_r ? ST_MIX0 : ST_IDX;
      ST_IDX:       state_next = ST_RD0;
      ST_RD0:       state_next = ST_RD1;
      ST_RD1:       state_next = ST_DIF;
      ST_DIF:       state_next = ST_W1;
      ST_W1:        state_next = ST_W2;
      ST_W2:        state_next = ST_W3;
      ST_W3:        state_next = gsel ? ST_MIX0 : ST_IDX;
      ST_MIX0:      state_next = ST_MIX1;
      ST_MIX1:      state_next = ST_MIX2;
      ST_MIX2:      state_next = ST_MIX3;
      ST_MIX3:      state_next = ST_DONE;
      ST_DONE:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_CLEAR;
    endcase
  end

  // Store port and multiplier operand selection.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = wp;
    mem_wr_data = sample_r;
    mem_rd_addr = i0_r;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt;
        mem_wr_data = '0;
      end
      ST_WRITE: begin
        mem_wr_en = 1'b1;
      end
      ST_DRY: begin
        mem_rd_addr = wp - DRY_OFF;
      end
      ST_IDX: begin
        mul_a = MUL_A_W'({1'b0, pos});
        mul_b = MUL_B_W'({1'b0, ratio_c});
      end
      ST_RD0: begin
        mem_rd_addr = idx_sum[IDX_W-1:16];
      end
      ST_RD1: begin
        mem_rd_addr = i0_r + ADDR_W'(1);
      end
      ST_DIF: begin
        mul_a = MUL_A_W'(s_diff);
        mul_b = MUL_B_W'({1'b0, frac_r});
      end
      ST_W1: begin
        mul_a = s0ph;
        mul_b = MUL_B_W'({1'b0, win});
      end
      ST_W2: begin
        mul_a = MUL_A_W'({1'b0, pl_r});
        mul_b = MUL_B_W'({1'b0, win});
      end
      ST_MIX0: begin
        mul_a = MUL_A_W'(dry_r);
        mul_b = MUL_B_W'({1'b0, dry_gain});
      end
      ST_MIX1: begin
        mul_a = MUL_A_W'(acc >>> 16);
        mul_b = MUL_B_W'({1'b0, mix_c});
      end
      ST_MIX2: begin
        mul_a = MUL_A_W'({1'b0, acc[15:0]});
        mul_b = MUL_B_W'({1'b0, mix_c});
      end
      default: begin
      end
    endcase
  end

  // Datapath and grain state.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= '0;
      pos           <= '0;
      start1        <= '0;
      start2        <= '0;
      unstarted     <= 1'b1;
      clr_cnt       <= '0;
      m_axis_tvalid <= 1'b0;
      gsel          <= 1'b0;
    end else begin
      // The result register empties when taken, unless a new result lands at once.
      if (m_axis_tvalid && m_axis_tready && state != ST_DONE) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + ADDR_W'(1);
        end
        ST_IDLE: begin
          if (in_acc) begin
            sample_r <= s_axis_tdata;
            ratio_c  <= ratio_in;
            mix_c    <= mix_in;
            bypass_r <= bypass_in;
            gsel     <= 1'b0;
            acc      <= '0;
            if (unstarted) begin
              start1    <= st1_new;
              start2    <= st2_new;
              pos       <= '0;
              unstarted <= 1'b0;
            end
          end
        end
        ST_DRY_LATCH: begin
          dry_r <= mem_rd_data;
        end
        ST_RD0: begin
          i0_r   <= idx_sum[IDX_W-1:16];
          frac_r <= idx_sum[15:0];
        end
        ST_RD1: begin
          s0_r <= mem_rd_data;
        end
        ST_W1: begin
          pl_r <= prod[15:0];
        end
        ST_W2: begin
          acc <= acc + 44'(prod);
        end
        ST_W3: begin
          acc  <= acc + 44'(prod >>> 16);
          gsel <= 1'b1;
        end
        ST_MIX1: begin
          tot <= prod;
        end
        ST_MIX2: begin
          tot <= tot + prod;
        end
        ST_MIX3: begin
          if (fin_hi > 32'sd8388607) begin
            sat_r <= 24'h7FFFFF;
          end else if (fin_hi < -32'sd8388608) begin
            sat_r <= 24'h800000;
          end else begin
            sat_r <= fin_hi[SAMPLE_W-1:0];
          end
        end
        ST_DONE: begin
          if (out_free) begin
            res_r         <= sat_r;
            m_axis_tvalid <= 1'b1;
            if (!bypass_r) begin
              if (pos == LAST_POS) begin
                pos    <= '0;
                start1 <= st1_new;
                start2 <= st2_new;
              end else begin
                pos <= pos + POS_W'(1);
              end
            end
            wp <= wp + ADDR_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  tgps_sample_mem #(
    .DEPTH(BUFFER_DEPTH)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  tgps_hann_rom #(
    .WINDOW_LENGTH(WINDOW_LENGTH)
  ) u_rom (
    .clk    (clk),
    .rd_addr(pos),
    .rd_data(win)
  );

  tgps_mul u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .prod(prod)
  );

  // An accepted item always starts with its store write.
  a_accept_writes: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_WRITE)
    else $error("accepted item did not start with a store write");

  // The grain position stays inside the window.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("grain position beyond the window");

  // Grains are started only by an accepted item.
  a_start_on_item: assert property (@(posedge clk) disable iff (rst)
    $fell(unstarted) |-> $past(in_acc))
    else $error("grains started without an item");

endmodule
